// ===== src/tlfp_pkg.sv =====
package tlfp_pkg;

  localparam int COORD_W     = 31;
  localparam int DIST_W      = 32;
  localparam int TRIG_W      = 32;
  localparam int COORD_WIDTH = 32;
  localparam int TRIG_FRAC   = 30;
  localparam int SQ_W        = 64;

  // Quotient widths of the projection and direction dividers.
  localparam int PROJ_QW = 32;
  localparam int TRIG_QW = 2 * TRIG_FRAC + 1;

  localparam logic [DIST_W:0] DIST_LIMIT = (COORD_WIDTH >= DIST_W) ?
      (DIST_W + 1)'((65'd1 << DIST_W) - 65'd1) :
      (DIST_W + 1)'((65'd1 << COORD_WIDTH) - 65'd1);

  localparam logic signed [TRIG_W-1:0] TRIG_ONE = TRIG_W'(64'd1 << TRIG_FRAC);

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } point_t;

  typedef point_t [2:0] verts_t;

  typedef logic [2:0][1:0] order_t;

  typedef struct packed {
    point_t a;
    point_t b;
    point_t c;
  } frame_t;

endpackage

// ===== src/tlfp_div.sv =====
module tlfp_div #(
  parameter int NUM_W = 95,
  parameter int DEN_W = 64,
  parameter int QUO_W = 32
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [QUO_W-1:0] quo
);

  localparam int UP_W = NUM_W - QUO_W;

  // Each step holds the partial remainder, and a word whose upper bits are the
  // dividend bits still to come and whose lower bits are the quotient so far.
  logic [DEN_W-1:0] rem_r   [QUO_W];
  logic [DEN_W-1:0] rem_next[QUO_W];
  logic [QUO_W-1:0] lq_r    [QUO_W];
  logic [QUO_W-1:0] lq_next [QUO_W];
  logic [DEN_W-1:0] den_r   [QUO_W];
  logic [DEN_W-1:0] den_next[QUO_W];

  always_comb begin
    logic [DEN_W-1:0] src_rem;
    logic [QUO_W-1:0] src_lq;
    logic [DEN_W-1:0] src_den;
    logic [DEN_W:0]   trial;
    logic             take;
    for (int i = 0; i < QUO_W; i++) begin
      if (i == 0) begin
        src_rem = DEN_W'(num[NUM_W-1 -: UP_W]);
        src_lq  = num[QUO_W-1:0];
        src_den = den;
      end else begin
        src_rem = rem_r[i-1];
        src_lq  = lq_r[i-1];
        src_den = den_r[i-1];
      end
      trial       = {src_rem, src_lq[QUO_W-1]};
      take        = (trial >= {1'b0, src_den});
      rem_next[i] = take ? DEN_W'(trial - {1'b0, src_den}) : trial[DEN_W-1:0];
      lq_next[i]  = {src_lq[QUO_W-2:0], take};
      den_next[i] = src_den;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < QUO_W; i++) begin
        rem_r[i] <= rem_next[i];
        lq_r[i]  <= lq_next[i];
        den_r[i] <= den_next[i];
      end
    end
  end

  assign quo = lq_r[QUO_W-1];

endmodule

// ===== src/tlfp_sqrt.sv =====
module tlfp_sqrt #(
  parameter int RAD_W = 64
) (
  input  logic               clk,
  input  logic               en,
  input  logic [RAD_W-1:0]   rad,
  output logic [RAD_W/2:0]   root
);

  localparam int RT_W  = RAD_W / 2;
  localparam int REM_W = RT_W + 2;

  logic [REM_W-1:0] rem_r    [RT_W];
  logic [REM_W-1:0] rem_next [RT_W];
  logic [RT_W-1:0]  rt_r     [RT_W];
  logic [RT_W-1:0]  rt_next  [RT_W];
  logic [RAD_W-1:0] rest_r   [RT_W];
  logic [RAD_W-1:0] rest_next[RT_W];
  logic             round_up;

  always_comb begin
    logic [REM_W-1:0] src_rem;
    logic [RT_W-1:0]  src_rt;
    logic [RAD_W-1:0] src_rest;
    logic [REM_W+1:0] cand;
    logic [REM_W+1:0] trial;
    logic             take;
    for (int i = 0; i < RT_W; i++) begin
      if (i == 0) begin
        src_rem  = '0;
        src_rt   = '0;
        src_rest = rad;
      end else begin
        src_rem  = rem_r[i-1];
        src_rt   = rt_r[i-1];
        src_rest = rest_r[i-1];
      end
      cand         = {src_rem, src_rest[RAD_W-1 -: 2]};
      trial        = (REM_W + 2)'({src_rt, 2'b01});
      take         = (cand >= trial);
      rem_next[i]  = take ? REM_W'(cand - trial) : REM_W'(cand);
      rt_next[i]   = {src_rt[RT_W-2:0], take};
      rest_next[i] = src_rest << 2;
    end
  end

  assign round_up = (rem_r[RT_W-1] > REM_W'(rt_r[RT_W-1]));

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < RT_W; i++) begin
        rem_r[i]  <= rem_next[i];
        rt_r[i]   <= rt_next[i];
        rest_r[i] <= rest_next[i];
      end
      root <= (RT_W + 1)'(rt_r[RT_W-1]) + (RT_W + 1)'(round_up);
    end
  end

endmodule

// ===== src/triangle_local_frame_params_top.sv =====
// Channel | Signals                              | Direction
// in      | in_valid, in_stall, v0_x .. v2_y     | request in, stall out
// out     | out_valid, out_stall, first_vertex .. | result out, stall in
//         | degenerate                           |
// A triangle enters every cycle unless in_stall is raised.
// The latency is set by the 61-step direction divider and the 31-step root unit.
// Reset clears only the valid bits of the pipeline and the output register.
// The pipeline advances whenever its last stage is empty or the output moves on,
// so bubbles close up behind a stalled result and no request is lost.
module triangle_local_frame_params_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic signed [30:0]  v0_x,
  input  logic signed [30:0]  v0_y,
  input  logic signed [30:0]  v1_x,
  input  logic signed [30:0]  v1_y,
  input  logic signed [30:0]  v2_x,
  input  logic signed [30:0]  v2_y,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          first_vertex,
  output logic [1:0]          second_vertex,
  output logic [1:0]          third_vertex,
  output logic signed [30:0]  origin_x,
  output logic signed [30:0]  origin_y,
  output logic [31:0]         dist_to_b,
  output logic [31:0]         dist_to_a,
  output logic [31:0]         dist_to_c,
  output logic signed [31:0]  axis_sine,
  output logic signed [31:0]  axis_cosine,
  output logic                degenerate
);

  localparam int CW       = tlfp_pkg::COORD_W;
  localparam int SW       = tlfp_pkg::SQ_W;
  localparam int PQ       = tlfp_pkg::PROJ_QW;
  localparam int TQ       = tlfp_pkg::TRIG_QW;
  localparam int TFRAC2   = 2 * tlfp_pkg::TRIG_FRAC;
  localparam int PNUM_W   = SW + PQ - 1;
  localparam int TNUM_W   = SW + TFRAC2;
  localparam int TRAD_W   = 2 * ((TQ + 1) / 2);
  localparam int DS       = SW / 2 + 1;
  localparam int TS       = TRAD_W / 2 + 1;
  localparam int F_N      = 11;
  localparam int LAST     = F_N + TQ + TS;
  localparam int ORG_DLY  = LAST - (F_N + PQ + 1);
  localparam int DIST_DLY = LAST - (F_N + PQ + 4 + DS + 1);
  localparam int SIDE_DLY = LAST - F_N;
  localparam int DW       = tlfp_pkg::DIST_W;

  typedef struct packed {
    tlfp_pkg::frame_t pts;
    logic             negx;
    logic             negy;
  } proj_side_t;

  typedef struct packed {
    tlfp_pkg::order_t ord;
    logic             degen;
    logic             sx;
    logic             sy;
  } side_t;

  typedef struct packed {
    logic [CW-1:0] ox;
    logic [CW-1:0] oy;
  } org_t;

  typedef struct packed {
    logic [DW-1:0] b;
    logic [DW-1:0] a;
    logic [DW-1:0] c;
  } dist_t;

  logic            en;
  logic [LAST-1:0] vld;

  // Stage 1: vertices and edge vectors.
  tlfp_pkg::verts_t   f1_v;
  logic signed [31:0] f1_e01x, f1_e01y, f1_e02x, f1_e02y, f1_e12x, f1_e12y;
  // Stage 2: squares and cross terms.
  tlfp_pkg::verts_t   f2_v;
  logic signed [63:0] f2_s01x, f2_s01y, f2_s02x, f2_s02y, f2_s12x, f2_s12y;
  logic signed [63:0] f2_c1, f2_c2;
  // Stage 3: squared lengths and orientation.
  tlfp_pkg::verts_t   f3_v;
  logic [SW-1:0]      f3_l01, f3_l02, f3_l12;
  logic               f3_ccw;
  // Stage 4: vertex order.
  tlfp_pkg::verts_t   f4_v;
  tlfp_pkg::order_t   f4_ord, f4_ord_next;
  // Stage 5: A, B and C.
  tlfp_pkg::frame_t   f5_f;
  tlfp_pkg::order_t   f5_ord;
  // Stage 6: AB and AC.
  tlfp_pkg::frame_t   f6_f;
  tlfp_pkg::order_t   f6_ord;
  logic signed [31:0] f6_abx, f6_aby, f6_acx, f6_acy;
  // Stage 7: products and magnitudes.
  tlfp_pkg::frame_t   f7_f;
  tlfp_pkg::order_t   f7_ord;
  logic signed [63:0] f7_sqx, f7_sqy, f7_px, f7_py;
  logic [31:0]        f7_mx, f7_my;
  logic               f7_sx, f7_sy;
  // Stage 8: squared length and dot product.
  tlfp_pkg::frame_t   f8_f;
  tlfp_pkg::order_t   f8_ord;
  logic [SW-1:0]      f8_lensq, f8_dot, f8_sqx, f8_sqy;
  logic [31:0]        f8_mx, f8_my;
  logic               f8_sx, f8_sy;
  // Stage 9: dot magnitude and signs.
  tlfp_pkg::frame_t   f9_f;
  tlfp_pkg::order_t   f9_ord;
  logic [SW-1:0]      f9_lensq, f9_dmag, f9_sqx, f9_sqy;
  logic [31:0]        f9_mx, f9_my;
  logic               f9_sx, f9_sy, f9_negx, f9_negy, f9_degen;
  // Stage 10: partial products.
  tlfp_pkg::frame_t   f10_f;
  tlfp_pkg::order_t   f10_ord;
  logic [SW-1:0]      f10_lensq, f10_sqx, f10_sqy;
  logic [63:0]        f10_plx, f10_phx, f10_ply, f10_phy;
  logic               f10_sx, f10_sy, f10_negx, f10_negy, f10_degen;
  // Stage 11: rounded numerators.
  tlfp_pkg::frame_t   f11_f;
  tlfp_pkg::order_t   f11_ord;
  logic [SW-1:0]      f11_lensq, f11_sqx, f11_sqy;
  logic [PNUM_W-1:0]  f11_pnx, f11_pny;
  logic               f11_sx, f11_sy, f11_negx, f11_negy, f11_degen;
  logic [95:0]        pnx_next, pny_next;

  // Origin and distance stages.
  logic [PQ-1:0]      pq_x, pq_y;
  proj_side_t         ps_dl [PQ];
  proj_side_t         ps_out;
  tlfp_pkg::frame_t   g1_f;
  logic signed [31:0] g1_ox, g1_oy;
  logic [32:0]        offx, offy, oxw, oyw;
  logic signed [31:0] g2_dbx, g2_dby, g2_dax, g2_day, g2_dcx, g2_dcy;
  logic signed [63:0] g3_sbx, g3_sby, g3_sax, g3_say, g3_scx, g3_scy;
  logic [SW-1:0]      g4_nb, g4_na, g4_nc;
  logic [DW:0]        rt_b, rt_a, rt_c;
  dist_t              g5_d;
  dist_t              dist_dl [DIST_DLY];
  org_t               org_dl  [ORG_DLY];
  side_t              side_dl [SIDE_DLY];

  // Direction path.
  logic [TQ-1:0]      tq_x, tq_y;
  logic [TRAD_W/2:0]  tr_x, tr_y;

  // Final result.
  side_t              fin_side;
  org_t               fin_org;
  dist_t              fin_dist;

  assign en       = !(out_valid && out_stall && vld[LAST-1]);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAST-2:0], in_valid};
    end
  end

  always_comb begin
    if (f3_l01 > f3_l02 && f3_l01 > f3_l12) begin
      f4_ord_next[0] = f3_ccw ? 2'd0 : 2'd1;
      f4_ord_next[1] = f3_ccw ? 2'd1 : 2'd0;
      f4_ord_next[2] = 2'd2;
    end else if (f3_l02 > f3_l12) begin
      f4_ord_next[0] = f3_ccw ? 2'd2 : 2'd0;
      f4_ord_next[1] = f3_ccw ? 2'd0 : 2'd2;
      f4_ord_next[2] = 2'd1;
    end else begin
      f4_ord_next[0] = f3_ccw ? 2'd1 : 2'd2;
      f4_ord_next[1] = f3_ccw ? 2'd2 : 2'd1;
      f4_ord_next[2] = 2'd0;
    end
  end

  assign pnx_next = {f10_phx, 32'd0} + {32'd0, f10_plx} + {33'd0, f10_lensq[SW-1:1]};
  assign pny_next = {f10_phy, 32'd0} + {32'd0, f10_ply} + {33'd0, f10_lensq[SW-1:1]};

  always_ff @(posedge clk) begin
    if (en) begin
      f1_v[0]  <= '{x: v0_x, y: v0_y};
      f1_v[1]  <= '{x: v1_x, y: v1_y};
      f1_v[2]  <= '{x: v2_x, y: v2_y};
      f1_e01x  <= {v1_x[30], v1_x} - {v0_x[30], v0_x};
      f1_e01y  <= {v1_y[30], v1_y} - {v0_y[30], v0_y};
      f1_e02x  <= {v2_x[30], v2_x} - {v0_x[30], v0_x};
      f1_e02y  <= {v2_y[30], v2_y} - {v0_y[30], v0_y};
      f1_e12x  <= {v2_x[30], v2_x} - {v1_x[30], v1_x};
      f1_e12y  <= {v2_y[30], v2_y} - {v1_y[30], v1_y};

      f2_v     <= f1_v;
      f2_s01x  <= 64'(f1_e01x) * 64'(f1_e01x);
      f2_s01y  <= 64'(f1_e01y) * 64'(f1_e01y);
      f2_s02x  <= 64'(f1_e02x) * 64'(f1_e02x);
      f2_s02y  <= 64'(f1_e02y) * 64'(f1_e02y);
      f2_s12x  <= 64'(f1_e12x) * 64'(f1_e12x);
      f2_s12y  <= 64'(f1_e12y) * 64'(f1_e12y);
      f2_c1    <= 64'(f1_e01x) * 64'(f1_e02y);
      f2_c2    <= 64'(f1_e01y) * 64'(f1_e02x);

      f3_v     <= f2_v;
      f3_l01   <= f2_s01x + f2_s01y;
      f3_l02   <= f2_s02x + f2_s02y;
      f3_l12   <= f2_s12x + f2_s12y;
      f3_ccw   <= !(f2_c1 < f2_c2);

      f4_v     <= f3_v;
      f4_ord   <= f4_ord_next;

      f5_f.a   <= f4_v[f4_ord[0]];
      f5_f.b   <= f4_v[f4_ord[1]];
      f5_f.c   <= f4_v[f4_ord[2]];
      f5_ord   <= f4_ord;

      f6_f     <= f5_f;
      f6_ord   <= f5_ord;
      f6_abx   <= {f5_f.b.x[CW-1], f5_f.b.x} - {f5_f.a.x[CW-1], f5_f.a.x};
      f6_aby   <= {f5_f.b.y[CW-1], f5_f.b.y} - {f5_f.a.y[CW-1], f5_f.a.y};
      f6_acx   <= {f5_f.c.x[CW-1], f5_f.c.x} - {f5_f.a.x[CW-1], f5_f.a.x};
      f6_acy   <= {f5_f.c.y[CW-1], f5_f.c.y} - {f5_f.a.y[CW-1], f5_f.a.y};

      f7_f     <= f6_f;
      f7_ord   <= f6_ord;
      f7_sqx   <= 64'(f6_abx) * 64'(f6_abx);
      f7_sqy   <= 64'(f6_aby) * 64'(f6_aby);
      f7_px    <= 64'(f6_abx) * 64'(f6_acx);
      f7_py    <= 64'(f6_aby) * 64'(f6_acy);
      f7_mx    <= f6_abx[31] ? 32'(-f6_abx) : f6_abx;
      f7_my    <= f6_aby[31] ? 32'(-f6_aby) : f6_aby;
      f7_sx    <= f6_abx[31];
      f7_sy    <= f6_aby[31];

      f8_f     <= f7_f;
      f8_ord   <= f7_ord;
      f8_lensq <= f7_sqx + f7_sqy;
      f8_dot   <= f7_px + f7_py;
      f8_sqx   <= f7_sqx;
      f8_sqy   <= f7_sqy;
      f8_mx    <= f7_mx;
      f8_my    <= f7_my;
      f8_sx    <= f7_sx;
      f8_sy    <= f7_sy;

      f9_f     <= f8_f;
      f9_ord   <= f8_ord;
      f9_lensq <= f8_lensq;
      f9_dmag  <= f8_dot[SW-1] ? SW'(-f8_dot) : f8_dot;
      f9_sqx   <= f8_sqx;
      f9_sqy   <= f8_sqy;
      f9_mx    <= f8_mx;
      f9_my    <= f8_my;
      f9_sx    <= f8_sx;
      f9_sy    <= f8_sy;
      f9_negx  <= f8_sx ^ f8_dot[SW-1];
      f9_negy  <= f8_sy ^ f8_dot[SW-1];
      f9_degen <= (f8_lensq == '0);

      f10_f     <= f9_f;
      f10_ord   <= f9_ord;
      f10_lensq <= f9_lensq;
      f10_sqx   <= f9_sqx;
      f10_sqy   <= f9_sqy;
      f10_plx   <= 64'(f9_mx) * 64'(f9_dmag[31:0]);
      f10_phx   <= 64'(f9_mx) * 64'(f9_dmag[63:32]);
      f10_ply   <= 64'(f9_my) * 64'(f9_dmag[31:0]);
      f10_phy   <= 64'(f9_my) * 64'(f9_dmag[63:32]);
      f10_sx    <= f9_sx;
      f10_sy    <= f9_sy;
      f10_negx  <= f9_negx;
      f10_negy  <= f9_negy;
      f10_degen <= f9_degen;

      f11_f     <= f10_f;
      f11_ord   <= f10_ord;
      f11_lensq <= f10_lensq;
      f11_sqx   <= f10_sqx;
      f11_sqy   <= f10_sqy;
      f11_pnx   <= pnx_next[PNUM_W-1:0];
      f11_pny   <= pny_next[PNUM_W-1:0];
      f11_sx    <= f10_sx;
      f11_sy    <= f10_sy;
      f11_negx  <= f10_negx;
      f11_negy  <= f10_negy;
      f11_degen <= f10_degen;
    end
  end

  tlfp_div #(.NUM_W(PNUM_W), .DEN_W(SW), .QUO_W(PQ)) u_pdiv_x (
    .clk(clk), .en(en), .num(f11_pnx), .den(f11_lensq), .quo(pq_x)
  );

  tlfp_div #(.NUM_W(PNUM_W), .DEN_W(SW), .QUO_W(PQ)) u_pdiv_y (
    .clk(clk), .en(en), .num(f11_pny), .den(f11_lensq), .quo(pq_y)
  );

  tlfp_div #(.NUM_W(TNUM_W), .DEN_W(SW), .QUO_W(TQ)) u_tdiv_x (
    .clk(clk), .en(en), .num({f11_sqx, TFRAC2'(0)}), .den(f11_lensq), .quo(tq_x)
  );

  tlfp_div #(.NUM_W(TNUM_W), .DEN_W(SW), .QUO_W(TQ)) u_tdiv_y (
    .clk(clk), .en(en), .num({f11_sqy, TFRAC2'(0)}), .den(f11_lensq), .quo(tq_y)
  );

  tlfp_sqrt #(.RAD_W(TRAD_W)) u_tsq_x (
    .clk(clk), .en(en), .rad(TRAD_W'(tq_x)), .root(tr_x)
  );

  tlfp_sqrt #(.RAD_W(TRAD_W)) u_tsq_y (
    .clk(clk), .en(en), .rad(TRAD_W'(tq_y)), .root(tr_y)
  );

  assign ps_out = ps_dl[PQ-1];
  assign offx   = ps_out.negx ? 33'(-{1'b0, pq_x}) : {1'b0, pq_x};
  assign offy   = ps_out.negy ? 33'(-{1'b0, pq_y}) : {1'b0, pq_y};
  assign oxw    = {{2{ps_out.pts.a.x[CW-1]}}, ps_out.pts.a.x} + offx;
  assign oyw    = {{2{ps_out.pts.a.y[CW-1]}}, ps_out.pts.a.y} + offy;

  always_ff @(posedge clk) begin
    if (en) begin
      ps_dl[0] <= '{pts: f11_f, negx: f11_negx, negy: f11_negy};
      for (int i = 1; i < PQ; i++) begin
        ps_dl[i] <= ps_dl[i-1];
      end

      g1_f   <= ps_out.pts;
      g1_ox  <= oxw[31:0];
      g1_oy  <= oyw[31:0];

      g2_dbx <= g1_ox - {g1_f.b.x[CW-1], g1_f.b.x};
      g2_dby <= g1_oy - {g1_f.b.y[CW-1], g1_f.b.y};
      g2_dax <= g1_ox - {g1_f.a.x[CW-1], g1_f.a.x};
      g2_day <= g1_oy - {g1_f.a.y[CW-1], g1_f.a.y};
      g2_dcx <= g1_ox - {g1_f.c.x[CW-1], g1_f.c.x};
      g2_dcy <= g1_oy - {g1_f.c.y[CW-1], g1_f.c.y};

      g3_sbx <= 64'(g2_dbx) * 64'(g2_dbx);
      g3_sby <= 64'(g2_dby) * 64'(g2_dby);
      g3_sax <= 64'(g2_dax) * 64'(g2_dax);
      g3_say <= 64'(g2_day) * 64'(g2_day);
      g3_scx <= 64'(g2_dcx) * 64'(g2_dcx);
      g3_scy <= 64'(g2_dcy) * 64'(g2_dcy);

      g4_nb  <= g3_sbx + g3_sby;
      g4_na  <= g3_sax + g3_say;
      g4_nc  <= g3_scx + g3_scy;

      g5_d.b <= (rt_b > tlfp_pkg::DIST_LIMIT) ? tlfp_pkg::DIST_LIMIT[DW-1:0] : rt_b[DW-1:0];
      g5_d.a <= (rt_a > tlfp_pkg::DIST_LIMIT) ? tlfp_pkg::DIST_LIMIT[DW-1:0] : rt_a[DW-1:0];
      g5_d.c <= (rt_c > tlfp_pkg::DIST_LIMIT) ? tlfp_pkg::DIST_LIMIT[DW-1:0] : rt_c[DW-1:0];

      dist_dl[0] <= g5_d;
      for (int i = 1; i < DIST_DLY; i++) begin
        dist_dl[i] <= dist_dl[i-1];
      end

      org_dl[0] <= '{ox: g1_ox[CW-1:0], oy: g1_oy[CW-1:0]};
      for (int i = 1; i < ORG_DLY; i++) begin
        org_dl[i] <= org_dl[i-1];
      end

      side_dl[0] <= '{ord: f11_ord, degen: f11_degen, sx: f11_sx, sy: f11_sy};
      for (int i = 1; i < SIDE_DLY; i++) begin
        side_dl[i] <= side_dl[i-1];
      end
    end
  end

  tlfp_sqrt #(.RAD_W(SW)) u_dsq_b (.clk(clk), .en(en), .rad(g4_nb), .root(rt_b));
  tlfp_sqrt #(.RAD_W(SW)) u_dsq_a (.clk(clk), .en(en), .rad(g4_na), .root(rt_a));
  tlfp_sqrt #(.RAD_W(SW)) u_dsq_c (.clk(clk), .en(en), .rad(g4_nc), .root(rt_c));

  assign fin_side = side_dl[SIDE_DLY-1];
  assign fin_org  = org_dl[ORG_DLY-1];
  assign fin_dist = dist_dl[DIST_DLY-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= vld[LAST-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || !out_stall) begin
      if (fin_side.degen) begin
        first_vertex  <= '0;
        second_vertex <= '0;
        third_vertex  <= '0;
        origin_x      <= '0;
        origin_y      <= '0;
        dist_to_b     <= '0;
        dist_to_a     <= '0;
        dist_to_c     <= '0;
        axis_sine     <= '0;
        axis_cosine   <= '0;
        degenerate    <= 1'b1;
      end else begin
        first_vertex  <= fin_side.ord[0];
        second_vertex <= fin_side.ord[1];
        third_vertex  <= fin_side.ord[2];
        origin_x      <= fin_org.ox;
        origin_y      <= fin_org.oy;
        dist_to_b     <= fin_dist.b;
        dist_to_a     <= fin_dist.a;
        dist_to_c     <= fin_dist.c;
        axis_sine     <= fin_side.sy ? 32'(-tr_y) : 32'(tr_y);
        axis_cosine   <= fin_side.sx ? 32'(-tr_x) : 32'(tr_x);
        degenerate    <= 1'b0;
      end
    end
  end

endmodule

// ===== src/tlfp_check.sv =====
module tlfp_check (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic signed [30:0] v0_x,
  input logic signed [30:0] v0_y,
  input logic signed [30:0] v1_x,
  input logic signed [30:0] v1_y,
  input logic signed [30:0] v2_x,
  input logic signed [30:0] v2_y,
  input logic               out_valid,
  input logic               out_stall,
  input logic [1:0]         first_vertex,
  input logic [1:0]         second_vertex,
  input logic [1:0]         third_vertex,
  input logic signed [30:0] origin_x,
  input logic signed [30:0] origin_y,
  input logic [31:0]        dist_to_b,
  input logic [31:0]        dist_to_a,
  input logic [31:0]        dist_to_c,
  input logic signed [31:0] axis_sine,
  input logic signed [31:0] axis_cosine,
  input logic               degenerate
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(origin_x) && $stable(dist_to_c) &&
                               $stable(axis_sine) && $stable(first_vertex))
    else $error("stalled result changed");

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> first_vertex == 2'd0 && second_vertex == 2'd0 &&
                                third_vertex == 2'd0 && dist_to_a == 32'd0 &&
                                axis_sine == 32'sd0 && axis_cosine == 32'sd0)
    else $error("degenerate result not cleared");

  a_order_perm: assert property (@(posedge clk) disable iff (rst)
    out_valid && !degenerate |-> first_vertex != second_vertex &&
                                 first_vertex != third_vertex &&
                                 second_vertex != third_vertex &&
                                 first_vertex != 2'd3 && second_vertex != 2'd3 &&
                                 third_vertex != 2'd3)
    else $error("vertex order is not a permutation");

  a_trig_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && !degenerate |-> axis_sine <= tlfp_pkg::TRIG_ONE &&
                                 axis_sine >= -tlfp_pkg::TRIG_ONE &&
                                 axis_cosine <= tlfp_pkg::TRIG_ONE &&
                                 axis_cosine >= -tlfp_pkg::TRIG_ONE)
    else $error("axis direction out of range");

endmodule

bind triangle_local_frame_params_top tlfp_check u_tlfp_check (.*);
